FILE: rtl/slxf_pkg.sv
// ----------------------------------------------------------------------------
// slxf_pkg
// Shared constants and types of the sync/length/XOR frame receiver.
// ----------------------------------------------------------------------------
package slxf_pkg;

	localparam int MaxFrame      = 64;
	localparam int PosW          = $clog2(MaxFrame);
	localparam int CountW        = PosW + 1;
	localparam int AddrW         = PosW + 1;
	localparam int PlenW         = 6;
	localparam int FrameOverhead = 7;
	localparam int PayloadOffset = 5;
	localparam int TypeOffset    = 4;
	localparam int HeaderBytes   = 4;

	localparam logic [7:0] SyncFirst  = 8'h55;
	localparam logic [7:0] SyncSecond = 8'hAA;

	typedef struct packed {
		logic             en;
		logic [AddrW-1:0] addr;
		logic [7:0]       data;
	} mem_wr_t;

	typedef struct packed {
		logic             slot;
		logic [7:0]       frame_type;
		logic [PlenW-1:0] payload_length;
		logic [15:0]      checksum_word;
	} desc_t;

endpackage

FILE: rtl/slxf_front.sv
// ----------------------------------------------------------------------------
// slxf_front
// Byte parser: hunts for sync, checks the length, stores the frame and
// checks the XOR; posts a descriptor for each good frame.
// ----------------------------------------------------------------------------
module slxf_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic [7:0]              rx_byte,
	input  logic                    desc_full,
	output logic                    desc_push,
	output slxf_pkg::desc_t         desc,
	output slxf_pkg::mem_wr_t       mem_wr
);

	logic [slxf_pkg::CountW-1:0] byte_count_q;
	logic [slxf_pkg::CountW-1:0] decl_len_q;
	logic [7:0]                  xor_q;
	logic                        slot_q;
	logic [7:0]                  len_hi_q;
	logic [7:0]                  type_q;
	logic [7:0]                  chk_hi_q;

	logic                        accept;
	logic [slxf_pkg::CountW-1:0] pos;
	logic [slxf_pkg::CountW-1:0] pos_p1;
	logic [slxf_pkg::CountW:0]   pos_p2;
	logic [15:0]                 len_full;
	logic                        len_ok;
	logic                        xor_en;
	logic                        chk_hit;
	logic                        at_end;
	logic                        good;

	always_comb begin
		accept   = push & ~desc_full;
		// resynchronise should the count ever run past the store
		pos      = (byte_count_q >= slxf_pkg::CountW'(slxf_pkg::MaxFrame)) ? '0 : byte_count_q;
		pos_p1   = pos + slxf_pkg::CountW'(1);
		pos_p2   = {1'b0, pos} + (slxf_pkg::CountW + 1)'(2);
		len_full = {len_hi_q, rx_byte};
		len_ok   = (len_full >= 16'(slxf_pkg::FrameOverhead)) &&
		           (len_full <= 16'(slxf_pkg::MaxFrame));
		xor_en   = (pos < slxf_pkg::CountW'(slxf_pkg::HeaderBytes)) ||
		           (pos_p2 < {1'b0, decl_len_q});
		chk_hit  = (pos_p2 == {1'b0, decl_len_q});
		at_end   = (pos >= slxf_pkg::CountW'(slxf_pkg::HeaderBytes)) && (pos_p1 >= decl_len_q);
		good     = at_end && (xor_q == rx_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			decl_len_q   <= '0;
			xor_q        <= '0;
			slot_q       <= 1'b0;
		end else if (accept) begin
			byte_count_q <= pos_p1;
			if (xor_en) begin
				xor_q <= xor_q ^ rx_byte;
			end
			if (pos == slxf_pkg::CountW'(0)) begin
				if (rx_byte != slxf_pkg::SyncFirst) begin
					byte_count_q <= '0;
					xor_q        <= '0;
				end
			end else if (pos == slxf_pkg::CountW'(1)) begin
				if (rx_byte != slxf_pkg::SyncSecond) begin
					byte_count_q <= '0;
					xor_q        <= '0;
				end
			end else if (pos == slxf_pkg::CountW'(3)) begin
				if (len_ok) begin
					decl_len_q <= len_full[slxf_pkg::CountW-1:0];
				end else begin
					decl_len_q   <= '0;
					byte_count_q <= '0;
					xor_q        <= '0;
				end
			end else if (at_end) begin
				byte_count_q <= '0;
				xor_q        <= '0;
				decl_len_q   <= '0;
				// hand the filled slot to the back end
				if (good) begin
					slot_q <= ~slot_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos == slxf_pkg::CountW'(2)) begin
				len_hi_q <= rx_byte;
			end
			if (pos == slxf_pkg::CountW'(slxf_pkg::TypeOffset)) begin
				type_q <= rx_byte;
			end
			if (chk_hit) begin
				chk_hi_q <= rx_byte;
			end
		end
	end

	always_comb begin
		desc_push           = accept & good;
		desc.slot           = slot_q;
		desc.frame_type     = type_q;
		desc.payload_length = slxf_pkg::PlenW'(decl_len_q -
		                      slxf_pkg::CountW'(slxf_pkg::FrameOverhead));
		desc.checksum_word  = {chk_hi_q, rx_byte};
		mem_wr.en           = accept;
		mem_wr.addr         = {slot_q, pos[slxf_pkg::PosW-1:0]};
		mem_wr.data         = rx_byte;
	end

endmodule

FILE: rtl/slxf_desc_fifo.sv
// ----------------------------------------------------------------------------
// slxf_desc_fifo
// Two-entry queue of frame descriptors between parser and result sequencer.
// ----------------------------------------------------------------------------
module slxf_desc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  slxf_pkg::desc_t wr_data,
	input  logic            rd_en,
	output slxf_pkg::desc_t rd_data,
	output logic            full,
	output logic            not_empty
);

	slxf_pkg::desc_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	always_comb begin
		full      = (count_q == 2'd2);
		not_empty = (count_q != 2'd0);
		rd_data   = entry_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: rtl/slxf_back.sv
// ----------------------------------------------------------------------------
// slxf_back
// Frame store and result sequencer: walks the payload of each descriptor
// and presents one result per byte (one if empty) in an output register.
// ----------------------------------------------------------------------------
module slxf_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  slxf_pkg::mem_wr_t           mem_wr,
	input  logic                        desc_valid,
	input  slxf_pkg::desc_t             desc,
	output logic                        desc_pop,
	input  logic                        pop,
	output logic                        empty,
	output logic [7:0]                  frame_type,
	output logic [slxf_pkg::PlenW-1:0]  payload_length,
	output logic [slxf_pkg::PlenW-1:0]  payload_index,
	output logic [7:0]                  payload_byte,
	output logic                        has_byte,
	output logic [15:0]                 checksum_word,
	output logic                        is_last
);

	typedef enum logic {
		ST_ISSUE,
		ST_LOAD
	} state_t;

	localparam int Depth = 2 * slxf_pkg::MaxFrame;

	logic [7:0]                 mem [Depth];
	logic [7:0]                 rd_data_s1;
	state_t                     state_q;
	logic [slxf_pkg::PlenW-1:0] k_q;
	logic                       out_valid_q;

	logic                       issue;
	logic                       has;
	logic                       last;
	logic [slxf_pkg::PosW-1:0]  rd_pos;

	always_comb begin
		issue    = (state_q == ST_ISSUE) && desc_valid && (!out_valid_q || pop);
		has      = (desc.payload_length != '0);
		last     = !has || (k_q == desc.payload_length - slxf_pkg::PlenW'(1));
		rd_pos   = slxf_pkg::PosW'(slxf_pkg::PayloadOffset) + slxf_pkg::PosW'(k_q);
		desc_pop = (state_q == ST_LOAD) && last;
		empty    = ~out_valid_q;
	end

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			mem[mem_wr.addr] <= mem_wr.data;
		end
		if (issue) begin
			rd_data_s1 <= mem[{desc.slot, rd_pos}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_ISSUE;
			k_q            <= '0;
			out_valid_q    <= 1'b0;
			frame_type     <= '0;
			payload_length <= '0;
			payload_index  <= '0;
			payload_byte   <= '0;
			has_byte       <= 1'b0;
			checksum_word  <= '0;
			is_last        <= 1'b0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ISSUE: begin
					if (issue) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					// output register is free here: the read was issued only then
					out_valid_q    <= 1'b1;
					frame_type     <= desc.frame_type;
					payload_length <= desc.payload_length;
					payload_index  <= has ? k_q : '0;
					payload_byte   <= has ? rd_data_s1 : 8'h00;
					has_byte       <= has;
					checksum_word  <= desc.checksum_word;
					is_last        <= last;
					k_q            <= last ? '0 : k_q + slxf_pkg::PlenW'(1);
					state_q        <= ST_ISSUE;
				end
				default: begin
					state_q <= ST_ISSUE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/sync_length_xor_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_length_xor_frame_receiver
// Receives bytes, finds 0x55 0xAA framed packets with a length field and an XOR-8
// check, and emits one result per payload byte of each good frame (one if empty).
// ----------------------------------------------------------------------------
//  channel  | handshake       | payload
//  ---------+-----------------+------------------------------------------------
//  input    | push / full     | rx_byte
//  result   | empty / pop     | frame_type, payload_length, payload_index,
//           |                 | payload_byte, has_byte, checksum_word, is_last
//
//  Bytes are taken one per cycle while full is low; the parser needs no gaps.
//  Each result goes through a frame store read, then the output register.
//  full rises while two good frames wait, as each one holds a store slot.
//  Reset clears parser, queue and sequencer at once; the store needs no clearing.
//  A stalled result holds in the output register; parsing goes on meanwhile.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_receiver (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [7:0]                  rx_byte,
	output logic                        empty,
	input  logic                        pop,
	output logic [7:0]                  frame_type,
	output logic [slxf_pkg::PlenW-1:0]  payload_length,
	output logic [slxf_pkg::PlenW-1:0]  payload_index,
	output logic [7:0]                  payload_byte,
	output logic                        has_byte,
	output logic [15:0]                 checksum_word,
	output logic                        is_last
);

	slxf_pkg::desc_t   desc_in;
	slxf_pkg::desc_t   desc_out;
	slxf_pkg::mem_wr_t mem_wr;
	logic              desc_push;
	logic              desc_pop;
	logic              desc_full;
	logic              desc_valid;

	assign full = desc_full;

	slxf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.rx_byte   (rx_byte),
		.desc_full (desc_full),
		.desc_push (desc_push),
		.desc      (desc_in),
		.mem_wr    (mem_wr)
	);

	slxf_desc_fifo u_desc_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (desc_push),
		.wr_data   (desc_in),
		.rd_en     (desc_pop),
		.rd_data   (desc_out),
		.full      (desc_full),
		.not_empty (desc_valid)
	);

	slxf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.mem_wr         (mem_wr),
		.desc_valid     (desc_valid),
		.desc           (desc_out),
		.desc_pop       (desc_pop),
		.pop            (pop),
		.empty          (empty),
		.frame_type     (frame_type),
		.payload_length (payload_length),
		.payload_index  (payload_index),
		.payload_byte   (payload_byte),
		.has_byte       (has_byte),
		.checksum_word  (checksum_word),
		.is_last        (is_last)
	);

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sync/length/XOR frame receiver. Bytes are fed
// through the push/full side in random bursts, and results are drained through
// the empty/pop side on a stall pattern of their own. A built-in frame parser
// predicts every result, and each popped transaction is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import slxf_pkg::*;

	localparam int RandomBytes = 120;
	localparam int CycleLimit  = 200000;
	localparam int HoldOffLen  = 400;

	typedef struct {
		logic [7:0] value;
		bit         hold_for_drain;
	} tx_item_t;

	typedef struct {
		logic [7:0]       frame_type;
		logic [PlenW-1:0] payload_length;
		logic [PlenW-1:0] payload_index;
		logic [7:0]       payload_byte;
		logic             has_byte;
		logic [15:0]      checksum_word;
		logic             is_last;
	} frame_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             push = 1'b0;
	logic             full;
	logic [7:0]       rx_byte = 8'h00;
	logic             empty;
	logic             pop = 1'b0;
	logic [7:0]       frame_type;
	logic [PlenW-1:0] payload_length;
	logic [PlenW-1:0] payload_index;
	logic [7:0]       payload_byte;
	logic             has_byte;
	logic [15:0]      checksum_word;
	logic             is_last;

	tx_item_t      tx_bytes[$];
	frame_result_t pending_results[$];

	// parser state of the prediction
	int         frame_pos = 0;
	int         frame_len = 0;
	logic [7:0] frame_xor = 8'h00;
	logic [7:0] frame_buf[MaxFrame];

	int error_count     = 0;
	int results_checked = 0;
	int good_frames     = 0;
	int checksum_drops  = 0;
	int header_rejects  = 0;
	int cycle_count     = 0;
	int sent_count      = 0;
	bit all_delivered   = 1'b1;

	// driver state
	bit took;
	bit offer;
	int burst_left = 5;
	int gap_left   = 0;

	// receiver state
	int hold_left = 0;
	bit hold_done = 1'b0;
	int mode_left = 0;
	int pop_mode  = 0;

	sync_length_xor_frame_receiver u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.rx_byte       (rx_byte),
		.empty         (empty),
		.pop           (pop),
		.frame_type    (frame_type),
		.payload_length(payload_length),
		.payload_index (payload_index),
		.payload_byte  (payload_byte),
		.has_byte      (has_byte),
		.checksum_word (checksum_word),
		.is_last       (is_last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run did not complete within %0d cycles", $time, CycleLimit);
		$display("[sync_length_xor_frame_receiver] ERROR");
		$finish;
	end

	task automatic restart_hunt();
		frame_pos = 0;
		frame_xor = 8'h00;
	endtask

	// Advance the parser by one received byte and queue any results it causes.
	task automatic parse_rx_byte(input logic [7:0] b);
		int            pos;
		int            plen;
		int            runs;
		logic [7:0]    chk_lo;
		logic [15:0]   cword;
		logic [7:0]    xr;
		frame_result_t r;
		pos = frame_pos;
		if (pos >= MaxFrame) begin
			restart_hunt();
			pos = 0;
		end
		frame_buf[pos] = b;
		frame_pos = pos + 1;
		if (pos < HeaderBytes || pos + 2 < frame_len)
			frame_xor = frame_xor ^ b;
		if (pos == 0) begin
			if (b != SyncFirst)
				restart_hunt();
		end else if (pos == 1) begin
			if (b != SyncSecond)
				restart_hunt();
		end else if (pos == 3) begin
			frame_len = {frame_buf[2], frame_buf[3]};
			if (frame_len > MaxFrame || frame_len < FrameOverhead) begin
				frame_len = 0;
				header_rejects++;
				restart_hunt();
			end
		end else if (pos > 3 && frame_pos >= frame_len) begin
			plen   = frame_len - FrameOverhead;
			chk_lo = frame_buf[frame_len - 1];
			cword  = {frame_buf[frame_len - 2], chk_lo};
			xr     = frame_xor;
			restart_hunt();
			frame_len = 0;
			if (xr != chk_lo) begin
				checksum_drops++;
			end else begin
				runs = (plen == 0) ? 1 : plen;
				for (int k = 0; k < runs; k++) begin
					r.frame_type     = frame_buf[TypeOffset];
					r.payload_length = plen[PlenW-1:0];
					r.payload_index  = (plen == 0) ? '0 : k[PlenW-1:0];
					r.payload_byte   = (plen == 0) ? 8'h00 : frame_buf[PayloadOffset + k];
					r.has_byte       = (plen != 0);
					r.checksum_word  = cword;
					r.is_last        = (k + 1 == runs);
					pending_results.push_back(r);
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endtask

	task automatic add_byte(input logic [7:0] v, input bit drain = 1'b0);
		tx_item_t it;
		it.value = v;
		it.hold_for_drain = drain;
		tx_bytes.push_back(it);
	endtask

	// Build a whole frame; bad_sum spoils the low checksum byte.
	task automatic add_frame(input logic [7:0] ftype, input int plen, input bit bad_sum,
			input bit drain = 1'b0);
		logic [15:0] len;
		logic [7:0]  x;
		logic [7:0]  pb;
		len = 16'(plen + FrameOverhead);
		x = SyncFirst ^ SyncSecond ^ len[15:8] ^ len[7:0] ^ ftype;
		add_byte(SyncFirst, drain);
		add_byte(SyncSecond);
		add_byte(len[15:8]);
		add_byte(len[7:0]);
		add_byte(ftype);
		for (int i = 0; i < plen; i++) begin
			pb = 8'($urandom_range(0, 255));
			x = x ^ pb;
			add_byte(pb);
		end
		add_byte(8'($urandom_range(0, 255)));
		add_byte(bad_sum ? (x ^ 8'($urandom_range(1, 255))) : x);
	endtask

	task automatic add_bad_header();
		logic [15:0] len;
		len = $urandom_range(0, 1) ? 16'($urandom_range(0, FrameOverhead - 1))
			: 16'($urandom_range(MaxFrame + 1, 65535));
		add_byte(SyncFirst);
		add_byte(SyncSecond);
		add_byte(len[15:8]);
		add_byte(len[7:0]);
	endtask

	// Stimulus and end of run.
	initial begin
		int added;
		int pick;
		int big_frames;
		bit mid_drain;
		added = 0;
		big_frames = 0;
		mid_drain = 1'b0;

		// hunt: wrong first byte, second byte not 0xAA, stray 0xAA
		add_byte(8'h00);
		add_byte(SyncFirst);
		add_byte(SyncFirst);
		add_byte(SyncSecond);
		// length below the minimum, then above the maximum
		add_byte(SyncFirst);
		add_byte(SyncSecond);
		add_byte(8'h00);
		add_byte(8'(FrameOverhead - 1));
		add_byte(SyncFirst);
		add_byte(SyncSecond);
		add_byte(8'h00);
		add_byte(8'(MaxFrame + 1));
		// empty payload, then a one-byte payload with a broken checksum
		add_frame(8'hFF, 0, 1'b0);
		add_frame(8'h00, 1, 1'b1);

		// longest frame after everything so far has been delivered
		add_frame(8'($urandom_range(0, 255)), MaxFrame - FrameOverhead, 1'b0, 1'b1);
		big_frames = 1;
		while (added < RandomBytes) begin
			pick = tx_bytes.size();
			if (!mid_drain && added > RandomBytes / 2) begin
				mid_drain = 1'b1;
				add_frame(8'($urandom_range(0, 255)), $urandom_range(0, 8), 1'b0, 1'b1);
			end else begin
				case ($urandom_range(0, 19))
					0, 1: begin
						repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
					end
					2: add_bad_header();
					3: add_frame(8'($urandom_range(0, 255)), $urandom_range(0, 8), 1'b1);
					4: begin
						// truncated frame: the next bytes are swallowed into it
						add_byte(SyncFirst);
						add_byte(SyncSecond);
						add_byte(8'h00);
						add_byte(8'($urandom_range(FrameOverhead, 16)));
						add_byte(8'($urandom_range(0, 255)));
					end
					5: begin
						if (big_frames < 2) begin
							big_frames++;
							add_frame(8'($urandom_range(0, 255)), MaxFrame - FrameOverhead,
								1'b0);
						end else begin
							add_frame(8'($urandom_range(0, 255)), $urandom_range(0, 8), 1'b0);
						end
					end
					default: add_frame(8'($urandom_range(0, 255)), $urandom_range(0, 8), 1'b0);
				endcase
			end
			added += tx_bytes.size() - pick;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sample between edges, once driver and monitor have both moved on
		while (tx_bytes.size() != 0 || pending_results.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0 || !empty) begin
			$display("%0t: %0d results still expected, empty=%b at end of run", $time,
				pending_results.size(), empty);
			error_count++;
		end
		$display("Sent %0d bytes; checked %0d results from %0d good frames.", sent_count,
			results_checked, good_frames);
		$display("Dropped %0d frames on checksum and %0d on length.", checksum_drops,
			header_rejects);
		if (error_count == 0) begin
			$display("[sync_length_xor_frame_receiver] OK");
		end else begin
			$display("[sync_length_xor_frame_receiver] ERROR");
		end
		$finish;
	end

	// Sender: bursts of random length with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			rx_byte <= 8'h00;
		end else begin
			took = push && !full;
			if (took) begin
				void'(tx_bytes.pop_front());
				sent_count <= sent_count + 1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end
			if (push && full) begin
				offer = 1'b1;
			end else if (gap_left != 0) begin
				gap_left--;
				offer = 1'b0;
			end else if (tx_bytes.size() == 0) begin
				offer = 1'b0;
			end else if (tx_bytes[0].hold_for_drain && (took || !all_delivered)) begin
				// hold until every expected result has been popped
				offer = 1'b0;
			end else begin
				offer = 1'b1;
			end
			push <= offer;
			if (offer)
				rx_byte <= tx_bytes[0].value;
		end
	end

	// Receiver: stall pattern of its own, with one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (!hold_done && sent_count >= 80) begin
			hold_done = 1'b1;
			hold_left = HoldOffLen;
			pop <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				pop_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(5, 60);
			end else begin
				mode_left--;
			end
			case (pop_mode)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				default: pop <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	// Monitor: predict on accepted bytes, check accepted results.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_delivered <= 1'b1;
		end else begin
			if (push && !full)
				parse_rx_byte(rx_byte);
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual type %h index %0d",
						$time, frame_type, payload_index);
					error_count++;
				end else begin
					check_field("frame_type", pending_results[0].frame_type, frame_type);
					check_field("payload_length", pending_results[0].payload_length,
						payload_length);
					check_field("payload_index", pending_results[0].payload_index,
						payload_index);
					check_field("payload_byte", pending_results[0].payload_byte, payload_byte);
					check_field("has_byte", pending_results[0].has_byte, has_byte);
					check_field("checksum_word", pending_results[0].checksum_word,
						checksum_word);
					check_field("is_last", pending_results[0].is_last, is_last);
					if (pending_results[0].is_last)
						good_frames++;
					void'(pending_results.pop_front());
					results_checked++;
				end
			end
			all_delivered <= (pending_results.size() == 0);
		end
	end

endmodule
